// ===== hdl/tun_pkg.sv =====
package tun_pkg;

  // Control that travels with each transaction down the pipeline
  typedef struct packed {
    logic valid;
    logic degen;
  } tun_ctl_t;

  // Vector lanes: x, y, z
  localparam int unsigned NumLanes = 3;

endpackage

// ===== hdl/triangle_unit_normal_core.sv =====
// Throughput: one triangle per cycle; busy is never raised.
// Five front stages form edges, cross product and squared length, then one
// cell per normal bit settles that bit for all three lanes, then one output stage.
// Reset (rst_ni low, asynchronous) clears all valid bits; the receiver cannot stall.
module triangle_unit_normal_core import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      a_x_i,
  input  logic signed [COORD_WIDTH-1:0]      a_y_i,
  input  logic signed [COORD_WIDTH-1:0]      a_z_i,
  input  logic signed [COORD_WIDTH-1:0]      b_x_i,
  input  logic signed [COORD_WIDTH-1:0]      b_y_i,
  input  logic signed [COORD_WIDTH-1:0]      b_z_i,
  input  logic signed [COORD_WIDTH-1:0]      c_x_i,
  input  logic signed [COORD_WIDTH-1:0]      c_y_i,
  input  logic signed [COORD_WIDTH-1:0]      c_z_i,
  output logic                               done_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_z_o,
  output logic                               degenerate_o
);

  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned EW  = COORD_WIDTH + 1;
  localparam int unsigned MW  = 2 * EW;
  localparam int unsigned SW  = 2 * MW + 2;
  localparam int unsigned RW  = 2 * MW + 2 * F + 8;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned OW  = F + 2;
  localparam int unsigned NC  = F + 1;
  localparam int unsigned LAT = F + 7;

  logic signed [COORD_WIDTH-1:0] v [9];
  tun_ctl_t             ctl_c [NC+1];
  logic        [SW-1:0] s_c   [NC+1];
  logic signed [RW-1:0] r_c   [NC+1][NumLanes];
  logic signed [RW-1:0] p_c   [NC+1][NumLanes];
  logic        [QW-1:0] q_c   [NC+1][NumLanes];
  logic                 neg_c [NC+1][NumLanes];
  logic signed [OW-1:0] norm_d [NumLanes], norm_q [NumLanes];
  logic                 done_q, degen_q;

  assign busy = 1'b0;
  assign v = '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i};

  tun_front #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (F)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .v_i      (v),
    .ctl_o    (ctl_c[0]),
    .s_o      (s_c[0]),
    .r_o      (r_c[0]),
    .p_o      (p_c[0]),
    .neg_o    (neg_c[0])
  );

  assign q_c[0] = '{default: '0};

  // One cell per quotient bit, most significant first
  for (genvar g = 0; g < NC; g++) begin : g_cell
    tun_cell #(
      .RW  (RW),
      .SW  (SW),
      .QW  (QW),
      .BIT (F - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[g]),
      .s_i    (s_c[g]),
      .r_i    (r_c[g]),
      .p_i    (p_c[g]),
      .q_i    (q_c[g]),
      .neg_i  (neg_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .s_o    (s_c[g+1]),
      .r_o    (r_c[g+1]),
      .p_o    (p_c[g+1]),
      .q_o    (q_c[g+1]),
      .neg_o  (neg_c[g+1])
    );
  end

  // Apply sign, force zero on a degenerate triangle
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (ctl_c[NC].degen) begin
        norm_d[l] = '0;
      end else if (neg_c[NC][l]) begin
        norm_d[l] = -$signed(OW'(q_c[NC][l]));
      end else begin
        norm_d[l] = $signed(OW'(q_c[NC][l]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_c[NC].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= norm_d;
    degen_q <= ctl_c[NC].degen;
  end

  assign done_o       = done_q;
  assign norm_x_o     = norm_q[0];
  assign norm_y_o     = norm_q[1];
  assign norm_z_o     = norm_q[2];
  assign degenerate_o = degen_q;

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without matching transaction");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0))
    else $error("degenerate result carries a nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o) |-> (norm_x_o != '0 || norm_y_o != '0 || norm_z_o != '0))
    else $error("regular triangle gave a zero normal");
`endif

endmodule

// ===== hdl/tun_front.sv =====
module tun_front import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14,
  localparam int unsigned EW = COORD_WIDTH + 1,
  localparam int unsigned PW = 2 * EW,
  localparam int unsigned NW = PW + 1,
  localparam int unsigned MW = PW,
  localparam int unsigned SW = 2 * MW + 2,
  localparam int unsigned RW = 2 * MW + 2 * NORMAL_FRAC_BITS + 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [COORD_WIDTH-1:0] v_i [9],
  output tun_ctl_t                      ctl_o,
  output logic        [SW-1:0]          s_o,
  output logic signed [RW-1:0]          r_o [NumLanes],
  output logic signed [RW-1:0]          p_o [NumLanes],
  output logic                          neg_o [NumLanes]
);

  logic [4:0] vld_q;

  logic signed [EW-1:0] e_d [NumLanes], e_q [NumLanes];
  logic signed [EW-1:0] f_d [NumLanes], f_q [NumLanes];
  logic signed [PW-1:0] pa_d [NumLanes], pa_q [NumLanes];
  logic signed [PW-1:0] pb_d [NumLanes], pb_q [NumLanes];
  logic signed [NW-1:0] n_d [NumLanes], n_q [NumLanes];
  logic signed [NW-1:0] nabs [NumLanes];
  logic        [MW-1:0] mag [NumLanes];
  logic      [2*MW-1:0] msq_d [NumLanes], msq_q [NumLanes];
  logic                 neg3_q [NumLanes];
  logic        [SW-1:0] s_d;
  logic                 degen_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], accept_i};
    end
  end

  // Edges, products, cross product, squares
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      e_d[i] = $signed({v_i[3+i][COORD_WIDTH-1], v_i[3+i]})
             - $signed({v_i[i][COORD_WIDTH-1], v_i[i]});
      f_d[i] = $signed({v_i[6+i][COORD_WIDTH-1], v_i[6+i]})
             - $signed({v_i[3+i][COORD_WIDTH-1], v_i[3+i]});
      pa_d[i] = PW'(e_q[(i+1)%3]) * PW'(f_q[(i+2)%3]);
      pb_d[i] = PW'(e_q[(i+2)%3]) * PW'(f_q[(i+1)%3]);
      n_d[i]  = $signed({pa_q[i][PW-1], pa_q[i]}) - $signed({pb_q[i][PW-1], pb_q[i]});
      nabs[i] = n_q[i][NW-1] ? -n_q[i] : n_q[i];
      mag[i]  = nabs[i][MW-1:0];
      msq_d[i] = (2*MW)'(mag[i]) * (2*MW)'(mag[i]);
    end
    s_d = SW'(msq_q[0]) + SW'(msq_q[1]) + SW'(msq_q[2]);
  end

  // Hold payload through the front stages
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumLanes; i++) begin
      e_q[i]    <= e_d[i];
      f_q[i]    <= f_d[i];
      pa_q[i]   <= pa_d[i];
      pb_q[i]   <= pb_d[i];
      n_q[i]    <= n_d[i];
      msq_q[i]  <= msq_d[i];
      neg3_q[i] <= n_q[i][NW-1];
      r_o[i]    <= $signed(RW'(msq_q[i]) << (2 * NORMAL_FRAC_BITS + 2))
                 - $signed(RW'(s_d));
      p_o[i]    <= -$signed(RW'(s_d));
      neg_o[i]  <= neg3_q[i];
    end
    s_o     <= s_d;
    degen_q <= (s_d == '0);
  end

  assign ctl_o.valid = vld_q[4];
  assign ctl_o.degen = degen_q;

endmodule

// ===== hdl/tun_cell.sv =====
module tun_cell import tun_pkg::*; #(
  parameter int unsigned RW  = 104,
  parameter int unsigned SW  = 70,
  parameter int unsigned QW  = 15,
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tun_ctl_t             ctl_i,
  input  logic        [SW-1:0] s_i,
  input  logic signed [RW-1:0] r_i [NumLanes],
  input  logic signed [RW-1:0] p_i [NumLanes],
  input  logic        [QW-1:0] q_i [NumLanes],
  input  logic                 neg_i [NumLanes],
  output tun_ctl_t             ctl_o,
  output logic        [SW-1:0] s_o,
  output logic signed [RW-1:0] r_o [NumLanes],
  output logic signed [RW-1:0] p_o [NumLanes],
  output logic        [QW-1:0] q_o [NumLanes],
  output logic                 neg_o [NumLanes]
);

  logic signed [RW-1:0] s_ext;
  logic signed [RW-1:0] cand [NumLanes];

  // Trial of one quotient bit: residual minus the growth of (2q-1)^2 * s
  always_comb begin
    s_ext = $signed(RW'(s_i));
    for (int l = 0; l < NumLanes; l++) begin
      cand[l] = r_i[l] - (p_i[l] <<< (BIT + 2)) - (s_ext <<< (2 * BIT + 2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  // Keep the bit when the residual stays non-negative
  always_ff @(posedge clk_i) begin
    s_o <= s_i;
    for (int l = 0; l < NumLanes; l++) begin
      neg_o[l] <= neg_i[l];
      if (!cand[l][RW-1]) begin
        r_o[l] <= cand[l];
        p_o[l] <= p_i[l] + (s_ext <<< (BIT + 1));
        q_o[l] <= q_i[l] | (QW'(1) << BIT);
      end else begin
        r_o[l] <= r_i[l];
        p_o[l] <= p_i[l];
        q_o[l] <= q_i[l];
      end
    end
  end

endmodule
